/* src/atms_pkg.sv */
// types, codes and constants of the alarm slot table
package atms_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 16;
    localparam logic [7:0]  NONE_ID        = 8'd255;
    localparam logic [5:0]  SNOOZE_RESET   = 6'd5;
    localparam logic [6:0]  MIN_PER_HOUR   = 7'd60;
    localparam logic [5:0]  HOUR_PER_DAY   = 6'd24;
    localparam logic [7:0]  NO_MINUTE      = 8'd255;

    typedef enum logic [2:0] {
        CMD_WRITE   = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_CHECK   = 3'd2,
        CMD_SNOOZE  = 3'd3,
        CMD_DISMISS = 3'd4,
        CMD_READ    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    // stored slot word, msb first: done, enable, mask, minute, hour
    typedef struct packed {
        logic       done;
        logic       en;
        logic [6:0] mask;
        logic [5:0] mn;
        logic [4:0] hr;
    } slot_t;

endpackage

/* src/alarm_table_match_snooze.sv */
// alarm slot table with weekday match, one-shot alarms and snooze
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------------
//   in      | input     | in_valid / in_stall   | cmd alarm_id hour minute day_of_week
//           |           |                       | day_mask enable once_done
//   out     | output    | out_valid / out_stall | status ringing ringing_id snoozed fired
//           |           |                       | read_hour read_minute read_mask
//           |           |                       | read_enable read_done
//   cfg     | input     | cfg_valid / cfg_ready | snooze_step
//
// write, delete, snooze, dismiss and unused commands pass through EXEC and OUT; a read adds RDWAIT
// a time check that scans passes through SCAN before OUT: the scan reads one slot per cycle
// through the single read port of the slot memory
// one item is in work at a time; in_stall is high from acceptance until its result
// has moved into the output register, which then waits for out_stall to drop
// reset clears the present bits and ring state at once; there is no clearing pass
module alarm_table_match_snooze
    import atms_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  logic [7:0] alarm_id,
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    input  logic [2:0] day_of_week,
    input  logic [6:0] day_mask,
    input  logic       enable,
    input  logic       once_done,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic       ringing,
    output logic [7:0] ringing_id,
    output logic       snoozed,
    output logic       fired,
    output logic [4:0] read_hour,
    output logic [5:0] read_minute,
    output logic [6:0] read_mask,
    output logic       read_enable,
    output logic       read_done,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] snooze_step
);

    localparam int unsigned IDX_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [7:0]  SLOT_LIM = 8'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // latched item
    logic [2:0]       cmd_reg, cmd_next;
    logic [7:0]       id_reg, id_next;
    logic [4:0]       hour_reg, hour_next;
    logic [5:0]       minute_reg, minute_next;
    logic [2:0]       dow_reg, dow_next;
    logic [6:0]       mask_reg, mask_next;
    logic             en_reg, en_next;
    logic             done_reg, done_next;

    // block state
    logic [SLOT_COUNT-1:0] present_reg, present_next;
    logic             ring_reg, ring_next;
    logic [7:0]       ring_slot_reg, ring_slot_next;
    logic             snz_reg, snz_next;
    logic [4:0]       snz_hour_reg, snz_hour_next;
    logic [5:0]       snz_min_reg, snz_min_next;
    logic [7:0]       last_min_reg, last_min_next;
    logic [5:0]       snooze_cfg_reg, snooze_cfg_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;

    // staged result and output register
    logic [1:0]       res_status_reg, res_status_next;
    logic             res_fired_reg, res_fired_next;
    slot_t            res_word_reg, res_word_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic             out_ring_reg, out_ring_next;
    logic [7:0]       out_ring_id_reg, out_ring_id_next;
    logic             out_snz_reg, out_snz_next;
    logic             out_fired_reg, out_fired_next;
    slot_t            out_word_reg, out_word_next;

    // slot memory
    slot_t            mem [SLOT_COUNT];
    slot_t            mem_rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_t            mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    // decode helpers
    logic             id_ok;
    logic [IDX_W-1:0] id_idx;
    logic             id_present;
    logic [6:0]       min_sum;
    logic             min_wrap;
    logic [5:0]       hour_inc;
    logic [4:0]       snz_hour_calc;
    logic [5:0]       snz_min_calc;
    logic             new_minute;
    logic             snz_match;
    logic [7:0]       today_mask;
    logic             slot_hit;
    logic             out_free;

    assign id_ok      = (id_reg < SLOT_LIM);
    assign id_idx     = id_reg[IDX_W-1:0];
    assign id_present = id_ok && present_reg[id_idx];

    // snooze time: add once, wrap minute and hour at most once
    assign min_sum       = {1'b0, minute_reg} + {1'b0, snooze_cfg_reg};
    assign min_wrap      = (min_sum >= MIN_PER_HOUR);
    assign hour_inc      = {1'b0, hour_reg} + 6'd1;
    assign snz_min_calc  = min_wrap ? 6'(min_sum - MIN_PER_HOUR) : min_sum[5:0];
    assign snz_hour_calc = !min_wrap ? hour_reg :
                           (hour_inc >= HOUR_PER_DAY) ? 5'd0 : hour_inc[4:0];

    assign new_minute = ({2'b00, minute_reg} != last_min_reg);
    assign snz_match  = snz_reg && (hour_reg == snz_hour_reg) && (minute_reg == snz_min_reg);

    // match of the slot whose word has just come out of memory
    assign today_mask = {1'b0, mem_rdata_reg.mask};
    assign slot_hit   = present_reg[chk_idx_reg] && mem_rdata_reg.en && !mem_rdata_reg.done &&
                        (mem_rdata_reg.hr == hour_reg) && (mem_rdata_reg.mn == minute_reg) &&
                        ((mem_rdata_reg.mask == 7'd0) || today_mask[dow_reg]);

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        id_next          = id_reg;
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        dow_next         = dow_reg;
        mask_next        = mask_reg;
        en_next          = en_reg;
        done_next        = done_reg;
        present_next     = present_reg;
        ring_next        = ring_reg;
        ring_slot_next   = ring_slot_reg;
        snz_next         = snz_reg;
        snz_hour_next    = snz_hour_reg;
        snz_min_next     = snz_min_reg;
        last_min_next    = last_min_reg;
        snooze_cfg_next  = snooze_cfg_reg;
        chk_idx_next     = chk_idx_reg;
        res_status_next  = res_status_reg;
        res_fired_next   = res_fired_reg;
        res_word_next    = res_word_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_status_next  = out_status_reg;
        out_ring_next    = out_ring_reg;
        out_ring_id_next = out_ring_id_reg;
        out_snz_next     = out_snz_reg;
        out_fired_next   = out_fired_reg;
        out_word_next    = out_word_reg;
        mem_we           = 1'b0;
        mem_waddr        = id_idx;
        mem_wdata        = '{done: done_reg, en: en_reg, mask: mask_reg,
                             mn: minute_reg, hr: hour_reg};
        mem_raddr        = '0;

        if (cfg_valid)
        begin
            snooze_cfg_next = snooze_step;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = cmd;
                    id_next     = alarm_id;
                    hour_next   = hour;
                    minute_next = minute;
                    dow_next    = day_of_week;
                    mask_next   = day_mask;
                    en_next     = enable;
                    done_next   = once_done;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_fired_next  = 1'b0;
                res_word_next   = '0;
                state_next      = S_OUT;
                case (cmd_t'(cmd_reg))
                    CMD_WRITE:
                    begin
                        if (!id_ok)
                        begin
                            res_status_next = ST_BAD_ID;
                        end
                        else
                        begin
                            mem_we               = 1'b1;
                            present_next[id_idx] = 1'b1;
                        end
                    end

                    CMD_DELETE:
                    begin
                        if (!id_ok)
                        begin
                            res_status_next = ST_BAD_ID;
                        end
                        else if (!id_present)
                        begin
                            res_status_next = ST_ABSENT;
                        end
                        else
                        begin
                            present_next[id_idx] = 1'b0;
                        end
                    end

                    CMD_CHECK:
                    begin
                        if (new_minute)
                        begin
                            last_min_next = {2'b00, minute_reg};
                            if (snz_match)
                            begin
                                ring_next      = 1'b1;
                                snz_next       = 1'b0;
                                res_fired_next = 1'b1;
                            end
                            else
                            begin
                                mem_raddr    = '0;
                                chk_idx_next = '0;
                                state_next   = S_SCAN;
                            end
                        end
                    end

                    CMD_SNOOZE:
                    begin
                        if (ring_reg)
                        begin
                            ring_next     = 1'b0;
                            snz_next      = 1'b1;
                            snz_hour_next = snz_hour_calc;
                            snz_min_next  = snz_min_calc;
                        end
                    end

                    CMD_DISMISS:
                    begin
                        ring_next      = 1'b0;
                        snz_next       = 1'b0;
                        ring_slot_next = NONE_ID;
                    end

                    CMD_READ:
                    begin
                        if (!id_ok)
                        begin
                            res_status_next = ST_BAD_ID;
                        end
                        else if (!id_present)
                        begin
                            res_status_next = ST_ABSENT;
                        end
                        else
                        begin
                            mem_raddr  = id_idx;
                            state_next = S_RDWAIT;
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            S_RDWAIT:
            begin
                res_word_next = mem_rdata_reg;
                state_next    = S_OUT;
            end

            S_SCAN:
            begin
                // read of the following slot overlaps the check of this one
                mem_raddr = (chk_idx_reg == LAST_IDX) ? '0 : IDX_W'(chk_idx_reg + 1'b1);
                if (slot_hit)
                begin
                    ring_next      = 1'b1;
                    ring_slot_next = 8'(chk_idx_reg);
                    res_fired_next = 1'b1;
                    state_next     = S_OUT;
                    if (mem_rdata_reg.mask == 7'd0)
                    begin
                        // one-shot alarm retires after it fires
                        mem_we    = 1'b1;
                        mem_waddr = chk_idx_reg;
                        mem_wdata = '{done: 1'b1, en: 1'b0, mask: 7'd0,
                                      mn: mem_rdata_reg.mn, hr: mem_rdata_reg.hr};
                    end
                end
                else if (chk_idx_reg == LAST_IDX)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    chk_idx_next = IDX_W'(chk_idx_reg + 1'b1);
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_ring_next    = ring_reg;
                    out_ring_id_next = ring_slot_reg;
                    out_snz_next     = snz_reg;
                    out_fired_next   = res_fired_reg;
                    out_word_next    = res_word_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= '0;
            id_reg          <= '0;
            hour_reg        <= '0;
            minute_reg      <= '0;
            dow_reg         <= '0;
            mask_reg        <= '0;
            en_reg          <= 1'b0;
            done_reg        <= 1'b0;
            present_reg     <= '0;
            ring_reg        <= 1'b0;
            ring_slot_reg   <= NONE_ID;
            snz_reg         <= 1'b0;
            snz_hour_reg    <= '0;
            snz_min_reg     <= '0;
            last_min_reg    <= NO_MINUTE;
            snooze_cfg_reg  <= SNOOZE_RESET;
            chk_idx_reg     <= '0;
            res_status_reg  <= ST_OK;
            res_fired_reg   <= 1'b0;
            res_word_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_OK;
            out_ring_reg    <= 1'b0;
            out_ring_id_reg <= NONE_ID;
            out_snz_reg     <= 1'b0;
            out_fired_reg   <= 1'b0;
            out_word_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            id_reg          <= id_next;
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            dow_reg         <= dow_next;
            mask_reg        <= mask_next;
            en_reg          <= en_next;
            done_reg        <= done_next;
            present_reg     <= present_next;
            ring_reg        <= ring_next;
            ring_slot_reg   <= ring_slot_next;
            snz_reg         <= snz_next;
            snz_hour_reg    <= snz_hour_next;
            snz_min_reg     <= snz_min_next;
            last_min_reg    <= last_min_next;
            snooze_cfg_reg  <= snooze_cfg_next;
            chk_idx_reg     <= chk_idx_next;
            res_status_reg  <= res_status_next;
            res_fired_reg   <= res_fired_next;
            res_word_reg    <= res_word_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_ring_reg    <= out_ring_next;
            out_ring_id_reg <= out_ring_id_next;
            out_snz_reg     <= out_snz_next;
            out_fired_reg   <= out_fired_next;
            out_word_reg    <= out_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign ringing     = out_ring_reg;
    assign ringing_id  = out_ring_id_reg;
    assign snoozed     = out_snz_reg;
    assign fired       = out_fired_reg;
    assign read_hour   = out_word_reg.hr;
    assign read_minute = out_word_reg.mn;
    assign read_mask   = out_word_reg.mask;
    assign read_enable = out_word_reg.en;
    assign read_done   = out_word_reg.done;

    a_fired_rings: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> ringing && (status == ST_OK))
        else $error("fired result without ringing or with bad status");

    a_ring_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ringing |-> (ringing_id < SLOT_LIM))
        else $error("ringing with no valid slot id");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !$stable(state_reg))
        else $error("accepted item did not start work");

    a_scan_write_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && mem_we |-> slot_hit && (state_next == S_OUT))
        else $error("slot write-back during scan without a match");

endmodule

/* test/tb.sv */
// self-checking testbench of the alarm slot table with snooze
module tb;
    import atms_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 233;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] alarm_id;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] dow;
        logic [6:0] mask;
        logic       en;
        logic       dn;
    } alarm_item_t;

    typedef struct packed {
        status_t    status;
        logic       ringing;
        logic [7:0] ring_id;
        logic       snoozed;
        logic       fired;
        logic [4:0] rd_hour;
        logic [5:0] rd_minute;
        logic [6:0] rd_mask;
        logic       rd_en;
        logic       rd_done;
    } alarm_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] cmd;
    logic [7:0] alarm_id;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] day_of_week;
    logic [6:0] day_mask;
    logic       enable;
    logic       once_done;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] status;
    logic       ringing;
    logic [7:0] ringing_id;
    logic       snoozed;
    logic       fired;
    logic [4:0] read_hour;
    logic [5:0] read_minute;
    logic [6:0] read_mask;
    logic       read_enable;
    logic       read_done;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [5:0] snooze_step;

    alarm_table_match_snooze i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .alarm_id       (alarm_id),
        .hour           (hour),
        .minute         (minute),
        .day_of_week    (day_of_week),
        .day_mask       (day_mask),
        .enable         (enable),
        .once_done      (once_done),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .ringing        (ringing),
        .ringing_id     (ringing_id),
        .snoozed        (snoozed),
        .fired          (fired),
        .read_hour      (read_hour),
        .read_minute    (read_minute),
        .read_mask      (read_mask),
        .read_enable    (read_enable),
        .read_done      (read_done),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .snooze_step    (snooze_step)
    );

    // alarm table as the testbench expects it
    bit            slot_used [SLOTS];
    slot_t         slot_mem  [SLOTS];
    logic          ring_on  = 1'b0;
    logic [7:0]    ring_id  = NONE_ID;
    logic          snz_on   = 1'b0;
    logic [4:0]    snz_hr   = '0;
    logic [5:0]    snz_mn   = '0;
    logic [7:0]    last_mn  = NO_MINUTE;
    logic [5:0]    snz_step = SNOOZE_RESET;

    alarm_result_t pending_results [$];

    int n_err       = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_fired     = 0;
    int n_settings  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    // wall clock of the random traffic
    logic [4:0] now_hr;
    logic [5:0] now_mn;
    logic [2:0] now_dow;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic alarm_result_t compute_alarm_result(input alarm_item_t it);
        alarm_result_t r;
        int            i;
        int            m;
        int            h;
        bit            hit;
        r = '0;
        case (it.cmd)
            CMD_WRITE:
            begin
                if (it.alarm_id >= SLOTS)
                begin
                    r.status = ST_BAD_ID;
                end
                else
                begin
                    slot_mem[it.alarm_id] = '{done: it.dn, en: it.en, mask: it.mask,
                                              mn: it.minute, hr: it.hour};
                    slot_used[it.alarm_id] = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (it.alarm_id >= SLOTS)
                    r.status = ST_BAD_ID;
                else if (!slot_used[it.alarm_id])
                    r.status = ST_ABSENT;
                else
                    slot_used[it.alarm_id] = 1'b0;
            end
            CMD_CHECK:
            begin
                // only a new minute is looked at; the hour plays no part in that test
                if ({2'b00, it.minute} != last_mn)
                begin
                    last_mn = {2'b00, it.minute};
                    if (snz_on && it.hour == snz_hr && it.minute == snz_mn)
                    begin
                        ring_on = 1'b1;
                        snz_on  = 1'b0;
                        r.fired = 1'b1;
                    end
                    else
                    begin
                        hit = 1'b0;
                        for (i = 0; i < SLOTS && !hit; i++)
                        begin
                            if (slot_used[i] && slot_mem[i].en && !slot_mem[i].done &&
                                slot_mem[i].hr == it.hour && slot_mem[i].mn == it.minute &&
                                (slot_mem[i].mask == '0 ||
                                 ((slot_mem[i].mask >> it.dow) & 7'd1) != '0))
                            begin
                                // one-shot alarm retires itself
                                if (slot_mem[i].mask == '0)
                                begin
                                    slot_mem[i].en   = 1'b0;
                                    slot_mem[i].done = 1'b1;
                                end
                                ring_on = 1'b1;
                                ring_id = 8'(i);
                                r.fired = 1'b1;
                                hit     = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_SNOOZE:
            begin
                if (ring_on)
                begin
                    m = int'(it.minute) + int'(snz_step);
                    h = int'(it.hour);
                    if (m >= MIN_PER_HOUR)
                    begin
                        m = m - MIN_PER_HOUR;
                        h = h + 1;
                        if (h >= HOUR_PER_DAY)
                            h = 0;
                    end
                    ring_on = 1'b0;
                    snz_on  = 1'b1;
                    snz_hr  = 5'(h);
                    snz_mn  = 6'(m);
                end
            end
            CMD_DISMISS:
            begin
                ring_on = 1'b0;
                snz_on  = 1'b0;
                ring_id = NONE_ID;
            end
            CMD_READ:
            begin
                if (it.alarm_id >= SLOTS)
                begin
                    r.status = ST_BAD_ID;
                end
                else if (!slot_used[it.alarm_id])
                begin
                    r.status = ST_ABSENT;
                end
                else
                begin
                    r.rd_hour   = slot_mem[it.alarm_id].hr;
                    r.rd_minute = slot_mem[it.alarm_id].mn;
                    r.rd_mask   = slot_mem[it.alarm_id].mask;
                    r.rd_en     = slot_mem[it.alarm_id].en;
                    r.rd_done   = slot_mem[it.alarm_id].done;
                end
            end
            default:
            begin
            end
        endcase
        r.ringing = ring_on;
        r.ring_id = ring_id;
        r.snoozed = snz_on;
        return r;
    endfunction

    function automatic alarm_item_t pack_item(input logic [2:0] c, input logic [7:0] id,
                                              input logic [4:0] h, input logic [5:0] m,
                                              input logic [2:0] d, input logic [6:0] k,
                                              input logic e, input logic n);
        alarm_item_t it;
        it = '{cmd: c, alarm_id: id, hour: h, minute: m, dow: d, mask: k, en: e, dn: n};
        return it;
    endfunction

    task automatic send_item(input alarm_item_t it);
        int            gap;
        alarm_result_t want;
        in_valid    <= 1'b1;
        cmd         <= it.cmd;
        alarm_id    <= it.alarm_id;
        hour        <= it.hour;
        minute      <= it.minute;
        day_of_week <= it.dow;
        day_mask    <= it.mask;
        enable      <= it.en;
        once_done   <= it.dn;
        do
            @(posedge clk);
        while (in_stall);
        want = compute_alarm_result(it);
        pending_results.insert(pending_results.size(), want);
        n_items++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(0, 15);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_snooze_step(input logic [5:0] step);
        drain_results();
        cfg_valid   <= 1'b1;
        snooze_step <= step;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        snz_step = step;
        n_settings++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endtask

    function automatic alarm_item_t random_item();
        alarm_item_t it;
        int          pick;
        int          sel;
        int          m;
        int          h;
        // unused fields carry junk that the block has to ignore
        it.cmd      = 3'($urandom_range(0, 7));
        it.alarm_id = 8'($urandom_range(0, 255));
        it.hour     = 5'($urandom_range(0, 31));
        it.minute   = 6'($urandom_range(0, 63));
        it.dow      = 3'($urandom_range(0, 7));
        it.mask     = 7'($urandom_range(0, 127));
        it.en       = 1'($urandom_range(0, 1));
        it.dn       = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 38)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
            begin
                now_hr = 5'($urandom_range(0, 23));
                now_mn = 6'($urandom_range(0, 59));
            end
            else if (sel != 1)
            begin
                // sel 1 repeats the last minute
                if (now_mn == 6'd59)
                begin
                    now_mn = '0;
                    if (now_hr == 5'd23)
                    begin
                        now_hr  = '0;
                        now_dow = (now_dow == 3'd6) ? 3'd0 : now_dow + 3'd1;
                    end
                    else
                    begin
                        now_hr = now_hr + 5'd1;
                    end
                end
                else
                begin
                    now_mn = now_mn + 6'd1;
                end
            end
            it.cmd    = CMD_CHECK;
            it.hour   = now_hr;
            it.minute = now_mn;
            it.dow    = ($urandom_range(0, 29) == 0) ? 3'd7 : now_dow;
        end
        else if (pick < 58)
        begin
            it.cmd      = CMD_WRITE;
            it.alarm_id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(SLOTS, 255))
                                                      : 8'($urandom_range(0, SLOTS - 1));
            if ($urandom_range(0, 2) != 0)
            begin
                // a few minutes ahead so that it rings soon
                m = int'(now_mn) + $urandom_range(1, 6);
                h = int'(now_hr);
                if (m >= 60)
                begin
                    m = m - 60;
                    h = (h == 23) ? 0 : h + 1;
                end
                it.hour   = 5'(h);
                it.minute = 6'(m);
            end
            else
            begin
                it.hour   = 5'($urandom_range(0, 23));
                it.minute = 6'($urandom_range(0, 59));
            end
            case ($urandom_range(0, 3))
                0:       it.mask = '0;
                1:       it.mask = it.mask | 7'(1 << now_dow);
                2:       it.mask = it.mask;
                default: it.mask = 7'(1 << now_dow);
            endcase
            it.en = ($urandom_range(0, 6) != 0);
            it.dn = ($urandom_range(0, 9) == 0);
        end
        else if (pick < 74)
        begin
            it.cmd      = (pick < 64) ? CMD_DELETE : CMD_READ;
            it.alarm_id = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(SLOTS, 255))
                                                       : 8'($urandom_range(0, SLOTS - 1));
        end
        else if (pick < 84)
        begin
            it.cmd = CMD_SNOOZE;
            if ($urandom_range(0, 4) != 0)
            begin
                it.hour   = now_hr;
                it.minute = now_mn;
            end
        end
        else if (pick < 89)
        begin
            it.cmd = CMD_DISMISS;
        end
        else if (pick < 91)
        begin
            it.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        end
        return it;
    endfunction

    task automatic test_slot_access();
        send_item(pack_item(CMD_WRITE,  8'd0,   5'd7,  6'd30, 3'd0, 7'h7f, 1'b0, 1'b0));
        send_item(pack_item(CMD_WRITE,  8'd16,  5'd1,  6'd1,  3'd0, 7'h01, 1'b1, 1'b0));
        send_item(pack_item(CMD_WRITE,  8'd255, 5'd31, 6'd63, 3'd7, 7'h7f, 1'b1, 1'b1));
        send_item(pack_item(CMD_READ,   8'd15,  5'd0,  6'd0,  3'd0, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_DELETE, 8'd15,  5'd0,  6'd0,  3'd0, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_READ,   8'd255, 5'd0,  6'd0,  3'd0, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_DELETE, 8'd200, 5'd0,  6'd0,  3'd0, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_WRITE,  8'd15,  5'd31, 6'd63, 3'd7, 7'h7f, 1'b1, 1'b1));
        send_item(pack_item(CMD_READ,   8'd15,  5'd0,  6'd0,  3'd0, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_DELETE, 8'd15,  5'd0,  6'd0,  3'd0, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_READ,   8'd15,  5'd0,  6'd0,  3'd0, 7'h00, 1'b0, 1'b0));
    endtask

    task automatic test_time_match();
        // slot 0 is disabled, slot 2 is done, slot 4 rings on mondays, slot 6 is one-shot
        send_item(pack_item(CMD_WRITE, 8'd2, 5'd7, 6'd30, 3'd0, 7'h7f, 1'b1, 1'b1));
        send_item(pack_item(CMD_WRITE, 8'd4, 5'd7, 6'd30, 3'd0, 7'h02, 1'b1, 1'b0));
        send_item(pack_item(CMD_WRITE, 8'd6, 5'd7, 6'd30, 3'd0, 7'h00, 1'b1, 1'b0));
        send_item(pack_item(CMD_CHECK, 8'd0, 5'd7, 6'd30, 3'd1, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_CHECK, 8'd0, 5'd8, 6'd30, 3'd1, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_CHECK, 8'd0, 5'd7, 6'd31, 3'd7, 7'h00, 1'b0, 1'b0));
        // weekday seven: only the one-shot slot can match, it takes over the ring
        send_item(pack_item(CMD_CHECK, 8'd0, 5'd7, 6'd30, 3'd7, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_READ,  8'd6, 5'd0, 6'd0,  3'd0, 7'h00, 1'b0, 1'b0));
    endtask

    task automatic test_snooze_dismiss();
        // wraps past midnight with the reset step
        send_item(pack_item(CMD_SNOOZE,  8'd0, 5'd23, 6'd58, 3'd0, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_SNOOZE,  8'd0, 5'd1,  6'd1,  3'd0, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_CHECK,   8'd0, 5'd0,  6'd3,  3'd0, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_DELETE,  8'd6, 5'd0,  6'd0,  3'd0, 7'h00, 1'b0, 1'b0));
        send_item(pack_item(CMD_DISMISS, 8'd0, 5'd0,  6'd0,  3'd0, 7'h00, 1'b0, 1'b0));
    endtask

    task automatic test_spare_cmds();
        send_item(pack_item(CMD_SPARE_6, 8'd3, 5'd31, 6'd63, 3'd7, 7'h7f, 1'b1, 1'b1));
        send_item(pack_item(CMD_SPARE_7, 8'd1, 5'd7,  6'd30, 3'd1, 7'h00, 1'b1, 1'b0));
    endtask

    task automatic test_random_traffic();
        logic [5:0] steps [6];
        int         p;
        steps = '{6'd59, 6'd0, 6'($urandom_range(1, 10)), SNOOZE_RESET,
                  6'($urandom_range(0, 59)), 6'd30};
        now_hr  = 5'($urandom_range(0, 23));
        now_mn  = 6'($urandom_range(0, 59));
        now_dow = 3'($urandom_range(0, 6));
        for (p = 0; p < 6; p++)
        begin
            write_snooze_step(steps[p]);
            repeat (PHASE_ITEMS) send_item(random_item());
        end
    endtask

    // receiver stall in segments: none, coin toss, periodic, heavy
    initial
    begin : stall_pattern
        int seg;
        int mode;
        int period;
        int duty;
        int k;
        out_stall <= 1'b0;
        forever
        begin
            seg    = $urandom_range(16, 160);
            mode   = $urandom_range(0, 3);
            period = $urandom_range(2, 7);
            duty   = $urandom_range(1, period - 1);
            for (k = 0; k < seg; k++)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= 1'($urandom_range(0, 1));
                    2:       out_stall <= ((k % period) < duty);
                    default: out_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        alarm_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding");
                n_err++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_results++;
                if (want.fired)
                    n_fired++;
                check_field("status",      want.status,    status);
                check_field("ringing",     want.ringing,   ringing);
                check_field("ringing_id",  want.ring_id,   ringing_id);
                check_field("snoozed",     want.snoozed,   snoozed);
                check_field("fired",       want.fired,     fired);
                check_field("read_hour",   want.rd_hour,   read_hour);
                check_field("read_minute", want.rd_minute, read_minute);
                check_field("read_mask",   want.rd_mask,   read_mask);
                check_field("read_enable", want.rd_en,     read_enable);
                check_field("read_done",   want.rd_done,   read_done);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        cmd         <= '0;
        alarm_id    <= '0;
        hour        <= '0;
        minute      <= '0;
        day_of_week <= '0;
        day_mask    <= '0;
        enable      <= 1'b0;
        once_done   <= 1'b0;
        cfg_valid   <= 1'b0;
        snooze_step <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_slot_access();
        test_time_match();
        test_snooze_dismiss();
        test_spare_cmds();
        test_random_traffic();

        drain_results();
        repeat (20) @(posedge clk);

        $display("covered %0d items and %0d results, %0d alarm starts",
                 n_items, n_results, n_fired);
        $display("snooze step written %0d times, extremes and reset value included",
                 n_settings);
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
